[hdl/stt_pkg.sv]
//------------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character class helpers for the source text
// tokenizer.
//------------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NUM  = 3'd1,
		MODE_NAME = 3'd2,
		MODE_OP   = 3'd3,
		MODE_STR  = 3'd4
	} lex_mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_END    = 2'd1,
		KIND_ERR    = 2'd2,
		KIND_UNTERM = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TT_INT     = 3'd0,
		TT_FLOAT   = 3'd1,
		TT_STRING  = 3'd2,
		TT_KEYWORD = 3'd3,
		TT_NAME    = 3'd4,
		TT_OPER    = 3'd5,
		TT_OPEN    = 3'd6,
		TT_CLOSE   = 3'd7
	} tok_type_t;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		tok_type_t  token_type;
	} result_t;

	// Up to three results caused by one input item, in emission order.
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     res;
	} bundle_t;

	function automatic result_t mk_res(kind_t k, logic [7:0] c, tok_type_t t);
		result_t r;
		r.kind       = k;
		r.char_value = c;
		r.token_type = t;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_opch(logic [7:0] c);
		return c inside {"+", "-", "*", "/", "%", "<", ">", ":", ",", ".", "=", "|",
			"^", "&", "!", "@", ";"};
	endfunction

	// Keyword index: 0 if, 1 else, 2 while, 3 for.
	function automatic logic [2:0] kw_len(logic [1:0] k);
		logic [2:0] l;
		case (k)
			2'd0: l = 3'd2;
			2'd1: l = 3'd4;
			2'd2: l = 3'd5;
			2'd3: l = 3'd3;
			default: l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] p);
		logic [7:0] e;
		case ({k, p})
			{2'd0, 3'd0}: e = "i";
			{2'd0, 3'd1}: e = "f";
			{2'd1, 3'd0}: e = "e";
			{2'd1, 3'd1}: e = "l";
			{2'd1, 3'd2}: e = "s";
			{2'd1, 3'd3}: e = "e";
			{2'd2, 3'd0}: e = "w";
			{2'd2, 3'd1}: e = "h";
			{2'd2, 3'd2}: e = "i";
			{2'd2, 3'd3}: e = "l";
			{2'd2, 3'd4}: e = "e";
			{2'd3, 3'd0}: e = "f";
			{2'd3, 3'd1}: e = "o";
			{2'd3, 3'd2}: e = "r";
			default:      e = 8'h00;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

[hdl/stt_if.sv]
//------------------------------------------------------------------------------
// stt_if
// Valid/ready channels for text bytes in and token results out.
//------------------------------------------------------------------------------
`default_nettype none

interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_value;
	logic [2:0] token_type;
	logic       last_of_run;

	modport source (output valid, kind, char_value, token_type, last_of_run, input ready);
	modport sink   (input valid, kind, char_value, token_type, last_of_run, output ready);
endinterface

`default_nettype wire

[hdl/stt_front.sv]
//------------------------------------------------------------------------------
// stt_front
// Lexer front end: accepts one text item per cycle while the queue has room,
// updates the lexer state and builds the bundle of results that the item causes.
//------------------------------------------------------------------------------
`default_nettype none

module stt_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	stt_in_if.sink           text,
	input  wire logic        q_ready,
	output logic             push,
	output stt_pkg::bundle_t push_data
);

	stt_pkg::lex_mode_t mode_q, mode_d;
	logic               dot_q, dot_d;
	logic               esc_q, esc_d;
	logic               dq_q, dq_d;
	logic [3:0]         km_q, km_d;
	logic [2:0]         wl_q, wl_d;

	logic               accept;
	logic               close_en;
	stt_pkg::tok_type_t close_type;
	logic [3:0]         km_base, km_name;
	logic [2:0]         wl_base, wl_name;
	logic [7:0]         c;

	assign c           = text.text_byte;
	assign text.ready  = q_ready;
	assign accept      = text.valid && q_ready;

	// End item of the open token, if any.
	always_comb begin
		logic kw;
		kw = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (km_q[k] && (stt_pkg::kw_len(2'(k)) == wl_q)) kw = 1'b1;
		end
		close_en   = 1'b1;
		close_type = stt_pkg::TT_OPER;
		case (mode_q)
			stt_pkg::MODE_NUM:  close_type = dot_q ? stt_pkg::TT_FLOAT : stt_pkg::TT_INT;
			stt_pkg::MODE_NAME: close_type = kw ? stt_pkg::TT_KEYWORD : stt_pkg::TT_NAME;
			stt_pkg::MODE_OP:   close_type = stt_pkg::TT_OPER;
			default:            close_en = 1'b0;
		endcase
	end

	// Keyword tracking for a name character; a new name starts from scratch.
	always_comb begin
		km_base = (mode_q == stt_pkg::MODE_NAME) ? km_q : 4'hF;
		wl_base = (mode_q == stt_pkg::MODE_NAME) ? wl_q : 3'd0;
		km_name = km_base;
		for (int k = 0; k < 4; k++) begin
			if (!((wl_base < stt_pkg::kw_len(2'(k))) &&
			      (stt_pkg::kw_char(2'(k), wl_base) == c))) km_name[k] = 1'b0;
		end
		wl_name = (wl_base == 3'd7) ? wl_base : wl_base + 3'd1;
	end

	always_comb begin
		logic [1:0]        n;
		logic              taken;
		stt_pkg::result_t [2:0] r;
		n      = 2'd0;
		taken  = 1'b0;
		r      = '0;
		mode_d = mode_q;
		dot_d  = dot_q;
		esc_d  = esc_q;
		dq_d   = dq_q;
		km_d   = km_q;
		wl_d   = wl_q;

		if (text.end_of_text) begin
			if (mode_q == stt_pkg::MODE_STR) begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_UNTERM, 8'h00, stt_pkg::TT_INT);
				n = n + 2'd1;
			end else if (close_en) begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'h00, close_type);
				n = n + 2'd1;
			end
			mode_d = stt_pkg::MODE_IDLE;
			dot_d  = 1'b0;
			esc_d  = 1'b0;
			dq_d   = 1'b0;
			km_d   = 4'hF;
			wl_d   = 3'd0;
		end else if (mode_q == stt_pkg::MODE_STR) begin
			if (esc_q) begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
				n = n + 2'd1;
				esc_d = 1'b0;
			end else if (c == (dq_q ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE)) begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_STRING);
				n = n + 2'd1;
				mode_d = stt_pkg::MODE_IDLE;
			end else begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
				n = n + 2'd1;
				if (c == stt_pkg::CH_BSLASH) esc_d = 1'b1;
			end
		end else begin
			if (mode_q == stt_pkg::MODE_NUM && (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT)) begin
				taken = 1'b1;
				if (c == stt_pkg::CH_DOT) dot_d = 1'b1;
			end else if (mode_q == stt_pkg::MODE_NAME && stt_pkg::is_word(c)) begin
				taken = 1'b1;
				km_d  = km_name;
				wl_d  = wl_name;
			end else if (mode_q == stt_pkg::MODE_OP && stt_pkg::is_opch(c)) begin
				taken = 1'b1;
			end

			if (taken) begin
				r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
				n = n + 2'd1;
			end else begin
				if (close_en) begin
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'h00, close_type);
					n = n + 2'd1;
				end
				mode_d = stt_pkg::MODE_IDLE;
				if (stt_pkg::is_space(c)) begin
					mode_d = stt_pkg::MODE_IDLE;
				end else if (stt_pkg::is_digit(c)) begin
					mode_d = stt_pkg::MODE_NUM;
					dot_d  = 1'b0;
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
				end else if (stt_pkg::is_word(c)) begin
					mode_d = stt_pkg::MODE_NAME;
					km_d   = km_name;
					wl_d   = wl_name;
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
				end else if (stt_pkg::is_opch(c)) begin
					mode_d = stt_pkg::MODE_OP;
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
				end else if (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_SQUOTE) begin
					mode_d = stt_pkg::MODE_STR;
					dq_d   = (c == stt_pkg::CH_DQUOTE);
					esc_d  = 1'b0;
				end else if (c == "(" || c == "{") begin
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_OPEN);
					n = n + 2'd1;
				end else if (c == ")" || c == "}") begin
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_CHAR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_END, 8'h00, stt_pkg::TT_CLOSE);
					n = n + 2'd1;
				end else begin
					r[n] = stt_pkg::mk_res(stt_pkg::KIND_ERR, c, stt_pkg::TT_INT);
					n = n + 2'd1;
				end
			end
		end

		push_data.count = n;
		push_data.res   = r;
		// Items that cause no result (separators, opening quotes) never enter the queue.
		push = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			dot_q  <= 1'b0;
			esc_q  <= 1'b0;
			dq_q   <= 1'b0;
			km_q   <= 4'hF;
			wl_q   <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			dot_q  <= dot_d;
			esc_q  <= esc_d;
			dq_q   <= dq_d;
			km_q   <= km_d;
			wl_q   <= wl_d;
		end
	end

endmodule

`default_nettype wire

[hdl/stt_queue.sv]
//------------------------------------------------------------------------------
// stt_queue
// Short first-in first-out queue of result bundles between the lexer front end
// and the output serializer.
//------------------------------------------------------------------------------
`default_nettype none

module stt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stt_pkg::bundle_t push_data,
	output logic                  push_ready,
	input  wire logic             pop,
	output logic                  pop_valid,
	output stt_pkg::bundle_t      pop_data
);

	stt_pkg::bundle_t               entry_q [stt_pkg::QDepth];
	logic [stt_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [stt_pkg::QCntW-1:0]      count_q;
	logic                           do_push, do_pop;

	assign push_ready = (count_q != stt_pkg::QCntW'(stt_pkg::QDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[hdl/stt_back.sv]
//------------------------------------------------------------------------------
// stt_back
// Output serializer: holds one bundle in registers and hands out its results
// one item per cycle while the receiver is ready, marking the last one of the bundle.
//------------------------------------------------------------------------------
`default_nettype none

module stt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire stt_pkg::bundle_t q_data,
	output logic                  q_pop,
	stt_out_if.source             tokens
);

	stt_pkg::bundle_t cur_q;
	logic             cur_valid_q;
	logic [1:0]       idx_q;
	logic             is_last;
	logic             take;
	stt_pkg::result_t sel;

	assign is_last = (idx_q == cur_q.count - 2'd1);
	assign take    = cur_valid_q && tokens.ready;
	assign q_pop   = q_valid && (!cur_valid_q || (take && is_last));

	always_comb begin
		case (idx_q)
			2'd0:    sel = cur_q.res[0];
			2'd1:    sel = cur_q.res[1];
			2'd2:    sel = cur_q.res[2];
			default: sel = cur_q.res[0];
		endcase
	end

	assign tokens.valid       = cur_valid_q;
	assign tokens.kind        = sel.kind;
	assign tokens.char_value  = sel.char_value;
	assign tokens.token_type  = sel.token_type;
	assign tokens.last_of_run = is_last;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (take) begin
			if (is_last) cur_valid_q <= 1'b0;
			else         idx_q       <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

[hdl/source_text_tokenizer.sv]
//------------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical tokenizer: text bytes in, token characters and end items
// with token types out.
//------------------------------------------------------------------------------
// Usage:
// The text channel takes one item per cycle: a text byte, or an end-of-text
// flag that closes any open token and returns the lexer to idle. The tokens
// channel gives one result item per cycle: token characters in order, an end
// item with the token type, error items for unknown bytes and for a string
// still open at end of text. last_of_run marks the final result of one text
// item; text items that cause no result (separators, opening quotes) give none.
// The front end classifies an item in the cycle it is accepted and writes its
// results into a four-entry queue. The output serializer loads a bundle from
// the queue into its output register once it has handed out the previous one,
// and the tokens channel shows the results from that register.
// Text is taken at one item per cycle while the queue has room; the output side
// delivers one result per cycle, so items that cause two or three results fill
// the queue and slow intake to the output rate.
// When the receiver stalls, the current result holds and the queue fills,
// after which text ready drops. Reset clears the lexer state, the queue and
// the output register; nothing is lost except items not yet delivered.
//------------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer (
	input wire logic  clk,
	input wire logic  arst_n,
	stt_in_if.sink    text,
	stt_out_if.source tokens
);

	logic             push;
	logic             push_ready;
	stt_pkg::bundle_t push_data;
	logic             pop;
	logic             pop_valid;
	stt_pkg::bundle_t pop_data;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.q_ready   (push_ready),
		.push      (push),
		.push_data (push_data)
	);

	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	stt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_data  (pop_data),
		.q_pop   (pop),
		.tokens  (tokens)
	);

endmodule

`default_nettype wire

[hdl/stt_checker.sv]
//------------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer's result channel.
//------------------------------------------------------------------------------
`default_nettype none

module stt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] char_value,
	input wire logic [2:0] token_type,
	input wire logic       last_of_run
);

	// A stalled result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({kind, char_value, token_type, last_of_run}))
		else $error("result changed while stalled");

	a_end_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stt_pkg::KIND_END |-> char_value == 8'h00)
		else $error("end item carries a character");

	a_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != stt_pkg::KIND_END |-> token_type == stt_pkg::TT_INT)
		else $error("non-end item carries a token type");

	// Errors always finish the results of their text item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == stt_pkg::KIND_ERR || kind == stt_pkg::KIND_UNTERM)
		|-> last_of_run)
		else $error("error item not last of its run");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.kind        (tokens.kind),
	.char_value  (tokens.char_value),
	.token_type  (tokens.token_type),
	.last_of_run (tokens.last_of_run)
);

`default_nettype wire

[verif/tb_source_text_tokenizer.sv]
//------------------------------------------------------------------------------
// tb_source_text_tokenizer
// Self-checking bench for the streaming tokenizer. A scoreboard tracks the
// lexer state and predicts the token characters, end items and error items
// for every accepted text item. Directed text covers the corner cases, then
// random token fragments with random handshake gaps, a long receiver stall
// and a full drain pause.
//------------------------------------------------------------------------------

module tb_source_text_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int TextItems = 320;

	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_RBRACE = "}";

	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		tok_type_t  ttype;
		logic       last;
	} token_result_t;

	class token_scoreboard;
		token_result_t expected_tokens[$];
		string         keywords[4];
		string         op_set;
		lex_mode_t     lexer_mode;
		logic          dot_seen;
		logic          in_escape;
		logic          double_quoted;
		logic [3:0]    kw_alive;
		logic [2:0]    word_len;
		int            errors;
		int            items_noted;
		int            results_checked;
		int            ends_by_type[8];
		int            unknown_errors;
		int            open_string_errors;

		function new();
			keywords[0] = "if";
			keywords[1] = "else";
			keywords[2] = "while";
			keywords[3] = "for";
			op_set = "+-*/%<>:,.=|^&!@;";
			errors = 0;
			items_noted = 0;
			results_checked = 0;
			unknown_errors = 0;
			open_string_errors = 0;
			foreach (ends_by_type[i]) ends_by_type[i] = 0;
			clear_lexer();
		endfunction

		function void clear_lexer();
			lexer_mode = MODE_IDLE;
			dot_seen = 1'b0;
			in_escape = 1'b0;
			double_quoted = 1'b0;
			kw_alive = 4'hF;
			word_len = 3'd0;
		endfunction

		function logic digit_char(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function logic word_char(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
		endfunction

		function logic blank_char(logic [7:0] c);
			return c == " " || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function logic op_char(logic [7:0] c);
			for (int i = 0; i < op_set.len(); i++) begin
				if (op_set[i] == c) begin
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void put(kind_t k, logic [7:0] c, tok_type_t t);
			token_result_t r;
			r.kind = k;
			r.ch = c;
			r.ttype = t;
			r.last = 1'b0;
			expected_tokens.push_back(r);
		endfunction

		// Drop every keyword that the new character at this position rules out.
		function void name_advance(logic [7:0] c);
			for (int k = 0; k < 4; k++) begin
				if (!(word_len < keywords[k].len() && keywords[k][word_len] == c)) begin
					kw_alive[k] = 1'b0;
				end
			end
			if (word_len < 3'd7) begin
				word_len++;
			end
		endfunction

		function void close_open();
			tok_type_t t;
			case (lexer_mode)
				MODE_NUM: begin
					t = dot_seen ? TT_FLOAT : TT_INT;
					put(KIND_END, 8'h00, t);
				end
				MODE_NAME: begin
					t = TT_NAME;
					for (int k = 0; k < 4; k++) begin
						if (kw_alive[k] && keywords[k].len() == word_len) begin
							t = TT_KEYWORD;
						end
					end
					put(KIND_END, 8'h00, t);
				end
				MODE_OP: begin
					put(KIND_END, 8'h00, TT_OPER);
				end
				default: begin
				end
			endcase
			lexer_mode = MODE_IDLE;
		endfunction

		function void note_text(logic [7:0] c, logic eot);
			int         prior_count;
			logic       taken;
			logic [7:0] closing;
			prior_count = expected_tokens.size();
			items_noted++;
			if (eot) begin
				if (lexer_mode == MODE_STR) begin
					put(KIND_UNTERM, 8'h00, TT_INT);
				end else begin
					close_open();
				end
				clear_lexer();
			end else if (lexer_mode == MODE_STR) begin
				closing = double_quoted ? CH_DQUOTE : CH_SQUOTE;
				if (in_escape) begin
					put(KIND_CHAR, c, TT_INT);
					in_escape = 1'b0;
				end else if (c == closing) begin
					put(KIND_END, 8'h00, TT_STRING);
					lexer_mode = MODE_IDLE;
				end else begin
					put(KIND_CHAR, c, TT_INT);
					if (c == CH_BSLASH) begin
						in_escape = 1'b1;
					end
				end
			end else begin
				taken = 1'b0;
				if (lexer_mode == MODE_NUM && (digit_char(c) || c == CH_DOT)) begin
					put(KIND_CHAR, c, TT_INT);
					if (c == CH_DOT) begin
						dot_seen = 1'b1;
					end
					taken = 1'b1;
				end else if (lexer_mode == MODE_NAME && word_char(c)) begin
					put(KIND_CHAR, c, TT_INT);
					name_advance(c);
					taken = 1'b1;
				end else if (lexer_mode == MODE_OP && op_char(c)) begin
					put(KIND_CHAR, c, TT_INT);
					taken = 1'b1;
				end
				// A byte that cannot extend the open token ends it first.
				if (!taken) begin
					close_open();
					if (blank_char(c)) begin
					end else if (digit_char(c)) begin
						lexer_mode = MODE_NUM;
						dot_seen = 1'b0;
						put(KIND_CHAR, c, TT_INT);
					end else if (word_char(c)) begin
						lexer_mode = MODE_NAME;
						kw_alive = 4'hF;
						word_len = 3'd0;
						name_advance(c);
						put(KIND_CHAR, c, TT_INT);
					end else if (op_char(c)) begin
						lexer_mode = MODE_OP;
						put(KIND_CHAR, c, TT_INT);
					end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
						lexer_mode = MODE_STR;
						double_quoted = (c == CH_DQUOTE);
						in_escape = 1'b0;
					end else if (c == CH_LPAREN || c == CH_LBRACE) begin
						put(KIND_CHAR, c, TT_INT);
						put(KIND_END, 8'h00, TT_OPEN);
					end else if (c == CH_RPAREN || c == CH_RBRACE) begin
						put(KIND_CHAR, c, TT_INT);
						put(KIND_END, 8'h00, TT_CLOSE);
					end else begin
						put(KIND_ERR, c, TT_INT);
					end
				end
			end
			if (expected_tokens.size() > prior_count) begin
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
			end
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			errors++;
		endtask

		task check_token(logic [1:0] k, logic [7:0] c, logic [2:0] t, logic l);
			token_result_t want;
			results_checked++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d char 8'h%02h type %0d",
					k, c, t));
				return;
			end
			want = expected_tokens.pop_front();
			if (k !== want.kind) begin
				report_mismatch($sformatf("result %0d: kind %0d, expected %s",
					results_checked, k, want.kind.name()));
			end
			if (c !== want.ch) begin
				report_mismatch($sformatf("result %0d: char 8'h%02h, expected 8'h%02h",
					results_checked, c, want.ch));
			end
			if (t !== want.ttype) begin
				report_mismatch($sformatf("result %0d: token type %0d, expected %s",
					results_checked, t, want.ttype.name()));
			end
			if (l !== want.last) begin
				report_mismatch($sformatf("result %0d: last_of_run %0b, expected %0b",
					results_checked, l, want.last));
			end
			case (want.kind)
				KIND_END: ends_by_type[want.ttype]++;
				KIND_ERR: unknown_errors++;
				KIND_UNTERM: open_string_errors++;
				default: begin
				end
			endcase
		endtask

		task flag_leftovers();
			if (expected_tokens.size() != 0) begin
				report_mismatch($sformatf("%0d expected results never arrived, first kind %s",
					expected_tokens.size(), expected_tokens[0].kind.name()));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic rush;
	logic hold_req;
	int   items_sent;

	stt_in_if  text_ch();
	stt_out_if tok_ch();

	token_scoreboard sb = new();

	source_text_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (tok_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 2);
		end else if (r < 96) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the item.
	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		gap = rush ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		sb.note_text(b, eot);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], 1'b0);
		end
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (sb.expected_tokens.size() != 0) @(posedge clk);
	endtask

	// One random token, mostly well formed, with some separators and noise.
	task automatic send_fragment();
		int         pick;
		int         n;
		int         k;
		string      w;
		string      letters;
		logic [7:0] qc;
		logic [7:0] ch;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
			n = $urandom_range(0, 4);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(CH_DOT, 1'b0);
				end else begin
					send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
				end
			end
		end else if (pick < 40) begin
			k = $urandom_range(0, 3);
			w = sb.keywords[k];
			case ($urandom_range(0, 3))
				0, 1: send_text(w);
				2: begin
					if ($urandom_range(0, 1) != 0) begin
						send_text(w.substr(0, $urandom_range(0, w.len() - 2)));
					end else begin
						send_text(w);
						repeat ($urandom_range(1, 4)) begin
							send_item(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
						end
					end
				end
				default: begin
					repeat ($urandom_range(1, 9)) begin
						send_item(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
					end
				end
			endcase
		end else if (pick < 55) begin
			repeat ($urandom_range(1, 3)) begin
				send_item(sb.op_set[$urandom_range(0, sb.op_set.len() - 1)], 1'b0);
			end
		end else if (pick < 70) begin
			qc = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
			send_item(qc, 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					send_item(CH_BSLASH, 1'b0);
					send_item(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					ch = 8'($urandom_range(0, 255));
					if (ch == qc || ch == CH_BSLASH) begin
						ch = "s";
					end
					send_item(ch, 1'b0);
				end
			end
			// Now and then the string is left open.
			if ($urandom_range(0, 9) != 0) begin
				send_item(qc, 1'b0);
			end
		end else if (pick < 78) begin
			case ($urandom_range(0, 3))
				0: send_item(CH_LPAREN, 1'b0);
				1: send_item(CH_LBRACE, 1'b0);
				2: send_item(CH_RPAREN, 1'b0);
				default: send_item(CH_RBRACE, 1'b0);
			endcase
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 1) != 0) begin
					send_item(" ", 1'b0);
				end else begin
					send_item(8'($urandom_range(9, 13)), 1'b0);
				end
			end
		end else if (pick < 95) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : token_sink
		int   stall_left;
		int   hold_left;
		logic rdy;
		stall_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (rush) begin
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				stall_left = pick_gap();
				rdy = (stall_left == 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end
			tok_ch.ready <= rdy;
			@(posedge clk);
			if (tok_ch.valid && tok_ch.ready) begin
				sb.check_token(tok_ch.kind, tok_ch.char_value, tok_ch.token_type,
					tok_ch.last_of_run);
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d results still expected", sb.expected_tokens.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : text_source
		int  settle;
		logic hold_done;
		logic drain_done;
		arst_n = 1'b0;
		rush = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.end_of_text = 1'b0;
		tok_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: unknown bytes at both extremes, a keyword cut by a bracket,
		// a float ended by an operator, an escaped quote and 8'hFF inside a
		// string, an empty string, end of text inside a string, in a number
		// and in idle.
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("if(7.+=}");
		send_text("\"\\\"");
		send_item(8'hFF, 1'b0);
		send_text("\"''_ '");
		send_item(8'hFF, 1'b1);
		send_text("9");
		send_item(8'h00, 1'b1);
		send_item(8'h5A, 1'b1);
		wait_for_drain();

		while (items_sent < TextItems) begin
			if ($urandom_range(0, 11) == 0) begin
				rush = ~rush;
			end
			// Long receiver stall while text keeps coming back to back.
			if (!hold_done && items_sent >= 120) begin
				hold_done = 1'b1;
				rush = 1'b1;
				hold_req = 1'b1;
			end
			if (!drain_done && items_sent >= 220) begin
				drain_done = 1'b1;
				rush = 1'b0;
				wait_for_drain();
			end
			send_fragment();
		end
		send_item(8'h00, 1'b1);
		@(negedge clk);
		text_ch.valid <= 1'b0;

		settle = 0;
		while (sb.expected_tokens.size() != 0 && settle < 5000) begin
			@(posedge clk);
			settle++;
		end
		repeat (20) @(posedge clk);
		sb.flag_leftovers();

		$display("Covered %0d text items, %0d results: %0d int, %0d float, %0d string, %0d keyword,",
			sb.items_noted, sb.results_checked, sb.ends_by_type[TT_INT],
			sb.ends_by_type[TT_FLOAT], sb.ends_by_type[TT_STRING], sb.ends_by_type[TT_KEYWORD]);
		$display("%0d name, %0d operator, %0d bracket tokens; %0d unknown bytes, %0d open strings.",
			sb.ends_by_type[TT_NAME], sb.ends_by_type[TT_OPER],
			sb.ends_by_type[TT_OPEN] + sb.ends_by_type[TT_CLOSE], sb.unknown_errors,
			sb.open_string_errors);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
